@@ rtl/core/vas_pkg.sv @@
// shared types and command codes for the voice allocator
package vas_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned RACK_W  = 4;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned OUT_W   = 5;
  localparam int unsigned VOICE_W = 4;

  localparam logic [CMD_W-1:0] CMD_NOTE_ON   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ALL_OFF   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KILL_RACK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LEVEL     = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [NOTE_W-1:0]  note;
    logic [RACK_W-1:0]  rack;
    logic [SLOT_W-1:0]  slot;
    logic [LEVEL_W-1:0] peak;
    logic               ended;
  } vas_cmd_t;

  typedef struct packed {
    logic               en;
    logic [STAMP_W-1:0] stamp;
  } vas_wr_t;

endpackage

@@ rtl/core/vas_cell.sv @@
// one voice of the allocator chain: voice state plus one scan step
module vas_cell #(
  parameter int unsigned CELL_IDX    = 0,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned CNT_W       = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vas_pkg::vas_cmd_t   cmd_i,
  input  vas_pkg::vas_wr_t    wr_i,
  input  logic [IDX_W-1:0]    wr_idx_i,
  input  logic                tok_i,
  input  logic [IDX_W+IDX_W+vas_pkg::LEVEL_W+vas_pkg::STAMP_W+CNT_W+CNT_W+1:0] acc_i,
  output logic                tok_o,
  output logic [IDX_W+IDX_W+vas_pkg::LEVEL_W+vas_pkg::STAMP_W+CNT_W+CNT_W+1:0] acc_o
);
  import vas_pkg::*;

  typedef struct packed {
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic [LEVEL_W-1:0] best_level;
    logic [STAMP_W-1:0] best_stamp;
    logic [IDX_W-1:0]   best_idx;
    logic [CNT_W-1:0]   touched;
    logic [CNT_W-1:0]   total;
    logic               busy;
  } acc_t;

  acc_t acc_in, acc_d, acc_q;

  logic               act_q, act_d;
  logic               rel_q, rel_d;
  logic [NOTE_W-1:0]  note_q, note_d;
  logic [RACK_W-1:0]  rack_q, rack_d;
  logic [LEVEL_W-1:0] lvl_q, lvl_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic               tok_q;
  logic               hit;
  logic               slot_match;
  logic               take;

  assign acc_in     = acc_i;
  assign slot_match = (32'(cmd_i.slot) == 32'(CELL_IDX));
  assign take       = (CELL_IDX == 0) || (lvl_q < acc_in.best_level) ||
                      ((lvl_q == acc_in.best_level) && (stamp_q < acc_in.best_stamp));

  always_comb begin
    act_d   = act_q;
    rel_d   = rel_q;
    note_d  = note_q;
    rack_d  = rack_q;
    lvl_d   = lvl_q;
    stamp_d = stamp_q;
    hit     = 1'b0;
    if (tok_i) begin
      case (cmd_i.cmd)
        CMD_NOTE_OFF: begin
          if (act_q && !rel_q && (note_q == cmd_i.note)) begin
            rel_d = 1'b1;
            hit   = 1'b1;
          end
        end
        CMD_ALL_OFF: begin
          hit   = act_q;
          act_d = 1'b0;
          lvl_d = '0;
        end
        CMD_KILL_RACK: begin
          if (act_q && (rack_q == cmd_i.rack)) begin
            act_d = 1'b0;
            lvl_d = '0;
            hit   = 1'b1;
          end
        end
        CMD_LEVEL: begin
          if (slot_match && act_q) begin
            lvl_d = cmd_i.peak;
            if (cmd_i.ended) begin
              act_d = 1'b0;
              lvl_d = '0;
              hit   = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (wr_i.en && (wr_idx_i == IDX_W'(CELL_IDX))) begin
      act_d   = 1'b1;
      rel_d   = 1'b0;
      note_d  = cmd_i.note;
      rack_d  = cmd_i.rack;
      lvl_d   = '0;
      stamp_d = wr_i.stamp;
    end
  end

  always_comb begin
    acc_d = acc_in;
    if (!acc_in.free_found && !act_q) begin
      acc_d.free_found = 1'b1;
      acc_d.free_idx   = IDX_W'(CELL_IDX);
    end
    if (take) begin
      acc_d.best_level = lvl_q;
      acc_d.best_stamp = stamp_q;
      acc_d.best_idx   = IDX_W'(CELL_IDX);
    end
    acc_d.touched = acc_in.touched + CNT_W'(hit);
    acc_d.total   = acc_in.total + CNT_W'(act_d);
    acc_d.busy    = acc_in.busy | (act_d && (rack_q == cmd_i.rack));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      rel_q   <= 1'b0;
      note_q  <= '0;
      rack_q  <= '0;
      lvl_q   <= '0;
      stamp_q <= '0;
      tok_q   <= 1'b0;
    end else begin
      act_q   <= act_d;
      rel_q   <= rel_d;
      note_q  <= note_d;
      rack_q  <= rack_d;
      lvl_q   <= lvl_d;
      stamp_q <= stamp_d;
      tok_q   <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign tok_o = tok_q;
  assign acc_o = acc_q;

endmodule

@@ rtl/core/voice_allocator_quietest_steal.sv @@
// voice allocator with quietest-voice stealing, top level
//
//   channel | direction | handshake               | fields
//   in      | input     | in_valid_i / in_stall_o   | command, note, rack_id, voice_slot,
//           |           |                           | peak_level, note_ended
//   out     | output    | out_valid_o / out_stall_i | chosen_voice, was_stolen,
//           |           |                           | voices_touched, rack_busy, active_total
//
// after accept the start flag is registered, a scan token walks the chain one cell per cycle,
// res_q latches the scan, and once out_free the result loads and the chosen voice is written
// one item is in flight at a time; in_stall_o is high from accept until the result loads
// the next item can be taken in the cycle after the result loads
// the result register holds while out_stall_i is high; the next item is accepted meanwhile
// reset clears every voice and the stamp counter at once, no clearing pass
module voice_allocator_quietest_steal #(
  parameter int unsigned VOICE_COUNT = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [vas_pkg::CMD_W-1:0]      command_i,
  input  logic [vas_pkg::NOTE_W-1:0]     note_i,
  input  logic [vas_pkg::RACK_W-1:0]     rack_id_i,
  input  logic [vas_pkg::SLOT_W-1:0]     voice_slot_i,
  input  logic [vas_pkg::LEVEL_W-1:0]    peak_level_i,
  input  logic                           note_ended_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [vas_pkg::VOICE_W-1:0]    chosen_voice_o,
  output logic                           was_stolen_o,
  output logic [vas_pkg::OUT_W-1:0]      voices_touched_o,
  output logic                           rack_busy_o,
  output logic [vas_pkg::OUT_W-1:0]      active_total_o
);
  import vas_pkg::*;

  localparam int unsigned IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(VOICE_COUNT + 1);
  localparam int unsigned ACC_W = IDX_W + IDX_W + LEVEL_W + STAMP_W + CNT_W + CNT_W + 2;

  typedef struct packed {
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic [LEVEL_W-1:0] best_level;
    logic [STAMP_W-1:0] best_stamp;
    logic [IDX_W-1:0]   best_idx;
    logic [CNT_W-1:0]   touched;
    logic [CNT_W-1:0]   total;
    logic               busy;
  } acc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e             state_q;
  vas_cmd_t           cmd_q;
  logic               start_q;
  logic [STAMP_W-1:0] stamp_q;
  acc_t               res_q;
  logic               out_valid_q;
  logic [VOICE_W-1:0] chosen_q;
  logic               stolen_q;
  logic [OUT_W-1:0]   touched_q;
  logic               busy_q;
  logic [OUT_W-1:0]   total_q;

  logic               tok [VOICE_COUNT+1];
  logic [ACC_W-1:0]   acc [VOICE_COUNT+1];
  acc_t               acc_end;

  logic               out_free;
  logic               is_on;
  logic [IDX_W-1:0]   chosen_idx;
  logic [CNT_W-1:0]   touched_fin;
  logic [CNT_W-1:0]   total_fin;
  logic               busy_fin;
  vas_wr_t            wr;

  assign tok[0] = start_q;
  assign acc[0] = '0;
  assign acc_end = acc[VOICE_COUNT];

  for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_cell
    vas_cell #(
      .CELL_IDX   (g),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd_q),
      .wr_i    (wr),
      .wr_idx_i(chosen_idx),
      .tok_i   (tok[g]),
      .acc_i   (acc[g]),
      .tok_o   (tok[g+1]),
      .acc_o   (acc[g+1])
    );
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_on       = (cmd_q.cmd == CMD_NOTE_ON);
  assign chosen_idx  = res_q.free_found ? res_q.free_idx : res_q.best_idx;
  assign touched_fin = res_q.touched;
  assign total_fin   = res_q.total + CNT_W'(is_on && res_q.free_found);
  assign busy_fin    = is_on | res_q.busy;
  assign wr.en       = (state_q == ST_DONE) && out_free && is_on;
  assign wr.stamp    = stamp_q + STAMP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      start_q     <= 1'b0;
      stamp_q     <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      chosen_q    <= '0;
      stolen_q    <= 1'b0;
      touched_q   <= '0;
      busy_q      <= 1'b0;
      total_q     <= '0;
    end else begin
      start_q <= (state_q == ST_IDLE) && in_valid_i;
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= '{cmd: command_i, note: note_i, rack: rack_id_i, slot: voice_slot_i,
                         peak: peak_level_i, ended: note_ended_i};
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tok[VOICE_COUNT]) begin
            res_q   <= acc_end;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            chosen_q    <= is_on ? VOICE_W'(chosen_idx) : '0;
            stolen_q    <= is_on && !res_q.free_found;
            touched_q   <= (touched_fin > 31) ? OUT_W'(31) : OUT_W'(touched_fin);
            busy_q      <= busy_fin;
            total_q     <= (total_fin > 31) ? OUT_W'(31) : OUT_W'(total_fin);
            if (is_on) begin
              stamp_q <= wr.stamp;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign chosen_voice_o   = chosen_q;
  assign was_stolen_o     = stolen_q;
  assign voices_touched_o = touched_q;
  assign rack_busy_o      = busy_q;
  assign active_total_o   = total_q;

endmodule

@@ rtl/core/vas_checker.sv @@
// port-level checks for the voice allocator, bound to the top level
module vas_checker #(
  parameter int unsigned VOICE_COUNT = 16
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [vas_pkg::VOICE_W-1:0] chosen_voice_o,
  input logic                        was_stolen_o,
  input logic [vas_pkg::OUT_W-1:0]   voices_touched_o,
  input logic                        rack_busy_o,
  input logic [vas_pkg::OUT_W-1:0]   active_total_o
);
  import vas_pkg::*;

  localparam logic [OUT_W-1:0] FULL = (VOICE_COUNT > 31) ? OUT_W'(31) : OUT_W'(VOICE_COUNT);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(chosen_voice_o) &&
      $stable(active_total_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in flight");

  a_steal_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_stolen_o |-> active_total_o == FULL)
    else $error("steal reported with a free voice");

  a_steal_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_stolen_o |-> rack_busy_o && voices_touched_o == '0)
    else $error("steal result inconsistent");

endmodule

bind voice_allocator_quietest_steal vas_checker #(.VOICE_COUNT(VOICE_COUNT)) u_vas_checker (.*);

@@ sim/vas_checker.sv @@
// voice allocator checker: mirrors the voice table and compares every result item
module vas_scoreboard (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [vas_pkg::CMD_W-1:0]   command_i,
  input  logic [vas_pkg::NOTE_W-1:0]  note_i,
  input  logic [vas_pkg::RACK_W-1:0]  rack_id_i,
  input  logic [vas_pkg::SLOT_W-1:0]  voice_slot_i,
  input  logic [vas_pkg::LEVEL_W-1:0] peak_level_i,
  input  logic                        note_ended_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [vas_pkg::VOICE_W-1:0] chosen_voice_i,
  input  logic                        was_stolen_i,
  input  logic [vas_pkg::OUT_W-1:0]   voices_touched_i,
  input  logic                        rack_busy_i,
  input  logic [vas_pkg::OUT_W-1:0]   active_total_i,
  output int                          pending_o,
  output int                          mismatches_o
);
  import vas_pkg::*;

  localparam int unsigned VOICES       = 16;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [VOICE_W-1:0] chosen;
    logic               stolen;
    logic [OUT_W-1:0]   touched;
    logic               busy;
    logic [OUT_W-1:0]   total;
  } voice_status_t;

  logic               voice_on    [VOICES];
  logic               voice_rel   [VOICES];
  logic [NOTE_W-1:0]  voice_key   [VOICES];
  logic [RACK_W-1:0]  voice_bus   [VOICES];
  logic [LEVEL_W-1:0] voice_gain  [VOICES];
  logic [STAMP_W-1:0] voice_age   [VOICES];
  logic [STAMP_W-1:0] age_counter;
  voice_status_t      predicted_status [$];

  // updates the mirrored voice table and returns the status item it implies
  function automatic voice_status_t apply_command(vas_cmd_t c);
    voice_status_t r;
    int unsigned   v;
    int unsigned   pick;
    int unsigned   touched;
    int unsigned   total;
    logic          found;
    r       = '0;
    pick    = 0;
    touched = 0;
    total   = 0;
    found   = 1'b0;
    case (c.cmd)
      CMD_NOTE_ON: begin
        for (v = 0; v < VOICES; v++) begin
          if (!found && !voice_on[v]) begin
            pick  = v;
            found = 1'b1;
          end
        end
        if (!found) begin
          // quietest voice, oldest stamp on a tie
          for (v = 1; v < VOICES; v++) begin
            if (voice_gain[v] < voice_gain[pick] ||
                (voice_gain[v] == voice_gain[pick] && voice_age[v] < voice_age[pick]))
              pick = v;
          end
          r.stolen = 1'b1;
        end
        voice_bus[pick]  = c.rack;
        voice_key[pick]  = c.note;
        voice_rel[pick]  = 1'b0;
        voice_on[pick]   = 1'b1;
        voice_gain[pick] = '0;
        age_counter      = age_counter + 1'b1;
        voice_age[pick]  = age_counter;
        r.chosen         = VOICE_W'(pick);
      end
      CMD_NOTE_OFF: begin
        for (v = 0; v < VOICES; v++) begin
          if (voice_on[v] && !voice_rel[v] && voice_key[v] == c.note) begin
            voice_rel[v] = 1'b1;
            touched++;
          end
        end
      end
      CMD_ALL_OFF: begin
        for (v = 0; v < VOICES; v++) begin
          if (voice_on[v]) touched++;
          voice_on[v]   = 1'b0;
          voice_gain[v] = '0;
        end
      end
      CMD_KILL_RACK: begin
        for (v = 0; v < VOICES; v++) begin
          if (voice_on[v] && voice_bus[v] == c.rack) begin
            voice_on[v]   = 1'b0;
            voice_gain[v] = '0;
            touched++;
          end
        end
      end
      CMD_LEVEL: begin
        if (c.slot < VOICES && voice_on[c.slot]) begin
          voice_gain[c.slot] = c.peak;
          if (c.ended) begin
            voice_on[c.slot]   = 1'b0;
            voice_gain[c.slot] = '0;
            touched            = 1;
          end
        end
      end
      default: begin
      end
    endcase
    for (v = 0; v < VOICES; v++) begin
      if (voice_on[v]) begin
        total++;
        if (voice_bus[v] == c.rack) r.busy = 1'b1;
      end
    end
    r.touched = (touched > 31) ? OUT_W'(31) : OUT_W'(touched);
    r.total   = (total > 31) ? OUT_W'(31) : OUT_W'(total);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    voice_status_t seen;
    voice_status_t want;
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        voice_on[v]   = 1'b0;
        voice_rel[v]  = 1'b0;
        voice_key[v]  = '0;
        voice_bus[v]  = '0;
        voice_gain[v] = '0;
        voice_age[v]  = '0;
      end
      age_counter = '0;
      predicted_status.delete();
      mismatches_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = {chosen_voice_i, was_stolen_i, voices_touched_i, rack_busy_i, active_total_i};
        if (predicted_status.size() == 0) begin
          if (mismatches_o < REPORT_LIMIT)
            $display("unexpected result item: voice %0d stolen %0d touched %0d busy %0d total %0d",
                     seen.chosen, seen.stolen, seen.touched, seen.busy, seen.total);
          mismatches_o++;
        end else begin
          want = predicted_status.pop_front();
          if (seen.chosen !== want.chosen || seen.stolen !== want.stolen ||
              seen.touched !== want.touched || seen.busy !== want.busy ||
              seen.total !== want.total) begin
            if (mismatches_o < REPORT_LIMIT)
              $display("mismatch: expected voice %0d stolen %0d touched %0d busy %0d total %0d, %s",
                       want.chosen, want.stolen, want.touched, want.busy, want.total,
                       $sformatf("got voice %0d stolen %0d touched %0d busy %0d total %0d",
                                 seen.chosen, seen.stolen, seen.touched, seen.busy,
                                 seen.total));
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        predicted_status = {predicted_status,
                            apply_command(vas_cmd_t'({command_i, note_i, rack_id_i,
                                                      voice_slot_i, peak_level_i,
                                                      note_ended_i}))};
    end
    pending_o = predicted_status.size();
  end

endmodule

@@ sim/testbench.sv @@
// voice allocator testbench top: clock, reset, stimulus, idling and verdict
module testbench;
  import vas_pkg::*;

  localparam int unsigned VOICES       = 16;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned CALM_ITEMS   = 200;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   command    = '0;
  logic [NOTE_W-1:0]  note       = '0;
  logic [RACK_W-1:0]  rack_id    = '0;
  logic [SLOT_W-1:0]  voice_slot = '0;
  logic [LEVEL_W-1:0] peak_level = '0;
  logic               note_ended = 1'b0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [VOICE_W-1:0] chosen_voice;
  logic               was_stolen;
  logic [OUT_W-1:0]   voices_touched;
  logic               rack_busy;
  logic [OUT_W-1:0]   active_total;
  int                 gap_pct    = 0;
  int                 stall_pct  = 0;
  int                 pending;
  int                 mismatches;

  always #4 clk = ~clk;

  voice_allocator_quietest_steal dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .note_i           (note),
    .rack_id_i        (rack_id),
    .voice_slot_i     (voice_slot),
    .peak_level_i     (peak_level),
    .note_ended_i     (note_ended),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .chosen_voice_o   (chosen_voice),
    .was_stolen_o     (was_stolen),
    .voices_touched_o (voices_touched),
    .rack_busy_o      (rack_busy),
    .active_total_o   (active_total)
  );

  vas_scoreboard checker_inst (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .command_i        (command),
    .note_i           (note),
    .rack_id_i        (rack_id),
    .voice_slot_i     (voice_slot),
    .peak_level_i     (peak_level),
    .note_ended_i     (note_ended),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .chosen_voice_i   (chosen_voice),
    .was_stolen_i     (was_stolen),
    .voices_touched_i (voices_touched),
    .rack_busy_i      (rack_busy),
    .active_total_i   (active_total),
    .pending_o        (pending),
    .mismatches_o     (mismatches)
  );

  function automatic vas_cmd_t make_item(logic [CMD_W-1:0] cmd, logic [NOTE_W-1:0] key,
                                         logic [RACK_W-1:0] rack, logic [SLOT_W-1:0] slot,
                                         logic [LEVEL_W-1:0] peak, logic ended);
    vas_cmd_t c;
    c.cmd   = cmd;
    c.note  = key;
    c.rack  = rack;
    c.slot  = slot;
    c.peak  = peak;
    c.ended = ended;
    return c;
  endfunction

  // notes and racks mostly come from small pools so note-offs and rack kills hit
  function automatic vas_cmd_t random_item();
    vas_cmd_t    c;
    int unsigned pick;
    pick  = $urandom_range(0, 99);
    c.cmd = (pick < 40) ? CMD_NOTE_ON :
            (pick < 60) ? CMD_NOTE_OFF :
            (pick < 82) ? CMD_LEVEL :
            (pick < 90) ? CMD_KILL_RACK :
            (pick < 94) ? CMD_ALL_OFF :
            CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    c.note = ($urandom_range(0, 4) != 0) ? NOTE_W'(60 + $urandom_range(0, 7)) :
                                           NOTE_W'($urandom_range(0, 127));
    c.rack = ($urandom_range(0, 9) < 7) ? RACK_W'($urandom_range(0, 3)) : RACK_W'($urandom);
    c.slot = SLOT_W'($urandom);
    pick   = $urandom_range(0, 9);
    c.peak = (pick == 0) ? '0 :
             (pick == 1) ? '1 :
             (pick < 4)  ? LEVEL_W'($urandom_range(0, 3)) : LEVEL_W'($urandom);
    c.ended = ($urandom_range(0, 3) == 0);
    return c;
  endfunction

  function automatic int idle_share();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 40;
    endcase
  endfunction

  task automatic send_item(input vas_cmd_t c);
    in_valid   <= 1'b1;
    command    <= c.cmd;
    note       <= c.note;
    rack_id    <= c.rack;
    voice_slot <= c.slot;
    peak_level <= c.peak;
    note_ended <= c.ended;
    do @(posedge clk); while (in_stall);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    vas_cmd_t    item;
    int unsigned counted;
    int unsigned loops;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct   = 20;
    stall_pct = 20;

    // empty table, then fill it, steal twice, release and kill voices and clear it again
    send_item(make_item(CMD_LEVEL, 7'h00, 4'h0, 4'h0, 16'hFFFF, 1'b1));
    send_item(make_item(CMD_SPARE_HI, 7'h7F, 4'hF, 4'hF, 16'hFFFF, 1'b1));
    for (int i = 0; i < VOICES; i++)
      send_item(make_item(CMD_NOTE_ON, i[0] ? 7'h7F : 7'h00, i[0] ? 4'hF : 4'h0,
                          4'h0, 16'h0000, 1'b0));
    send_item(make_item(CMD_NOTE_ON, 7'd64, 4'd3, 4'h0, 16'h0000, 1'b0));
    send_item(make_item(CMD_LEVEL, 7'h00, 4'd3, 4'd2, 16'hFFFF, 1'b0));
    send_item(make_item(CMD_NOTE_ON, 7'd65, 4'd3, 4'h0, 16'h0000, 1'b0));
    send_item(make_item(CMD_NOTE_OFF, 7'h7F, 4'hF, 4'h0, 16'h0000, 1'b0));
    send_item(make_item(CMD_NOTE_OFF, 7'h7F, 4'h0, 4'h0, 16'h0000, 1'b0));
    send_item(make_item(CMD_KILL_RACK, 7'h00, 4'hF, 4'h0, 16'h0000, 1'b0));
    send_item(make_item(CMD_LEVEL, 7'h00, 4'd3, 4'd4, 16'h0001, 1'b1));
    send_item(make_item(CMD_ALL_OFF, 7'h00, 4'd3, 4'h0, 16'h0000, 1'b0));

    counted = 0;
    loops   = 0;
    while (counted < RANDOM_ITEMS) begin
      if (loops % 100 == 0) begin
        gap_pct   = idle_share();
        stall_pct = idle_share();
      end
      if (counted >= RANDOM_ITEMS - CALM_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      item = random_item();
      counted++;
      send_item(item);
      loops++;
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (VOICES + 3 + 4) @(negedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ voice_allocator_quietest_steal.f @@
rtl/core/vas_pkg.sv
rtl/core/vas_cell.sv
rtl/core/voice_allocator_quietest_steal.sv
rtl/core/vas_checker.sv
sim/vas_checker.sv
sim/testbench.sv
